// File: design/aerp_pkg.sv
// aerp_pkg: widths, relocation type codes and status codes for the ARM ELF
// relocation patch unit. No dependencies.
`default_nettype none

package aerp_pkg;

	localparam int OPC_W  = 8;
	localparam int WORD_W = 32;

	typedef logic [OPC_W-1:0]  opcode_t;
	typedef logic [WORD_W-1:0] word_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNSUP = 2'd1,
		ST_THUMB = 2'd2
	} status_t;

	localparam opcode_t T_NONE       = 8'd0;
	localparam opcode_t T_PC24       = 8'd1;
	localparam opcode_t T_ABS32      = 8'd2;
	localparam opcode_t T_REL32      = 8'd3;
	localparam opcode_t T_THM_CALL   = 8'd10;
	localparam opcode_t T_GLOB_DAT   = 8'd21;
	localparam opcode_t T_JUMP_SLOT  = 8'd22;
	localparam opcode_t T_RELATIVE   = 8'd23;
	localparam opcode_t T_PLT32      = 8'd27;
	localparam opcode_t T_CALL       = 8'd28;
	localparam opcode_t T_JUMP24     = 8'd29;
	localparam opcode_t T_THM_JUMP24 = 8'd30;
	localparam opcode_t T_V4BX       = 8'd40;

	localparam word_t V4BX_KEEP = 32'hf000000f;
	localparam word_t V4BX_MOV  = 32'h01a0f000;
	localparam logic [15:0] THM_HI_KEEP = 16'hf800;
	localparam logic [15:0] THM_LO_KEEP = 16'hd000;

endpackage

`default_nettype wire

// File: design/aerp_if.sv
// aerp_req_if / aerp_rsp_if: valid/ready channels for relocation requests
// and patch results. Depends on aerp_pkg.
`default_nettype none

interface aerp_req_if import aerp_pkg::*; ();
	logic    valid;
	logic    ready;
	opcode_t opcode;
	word_t   word_in;
	word_t   place_addr;
	word_t   symbol_value;

	modport source (output valid, opcode, word_in, place_addr, symbol_value, input ready);
	modport sink   (input valid, opcode, word_in, place_addr, symbol_value, output ready);
endinterface

interface aerp_rsp_if import aerp_pkg::*; ();
	logic    valid;
	logic    ready;
	word_t   word_out;
	status_t status;

	modport source (output valid, word_out, status, input ready);
	modport sink   (input valid, word_out, status, output ready);
endinterface

`default_nettype wire

// File: design/arm_elf_relocation_patch_unit.sv
// arm_elf_relocation_patch_unit: patches one ARM ELF32 relocation per request.
// A request passes the input register and then the result register before its
// result is valid. Throughput: one request per cycle; the input stage holds
// while the result register is stalled. Reset (arst_n low, async) clears both
// stage valid flags; payload registers are not reset.
// Depends on aerp_pkg and aerp_if.
`default_nettype none

module arm_elf_relocation_patch_unit import aerp_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	aerp_req_if.sink    req,
	aerp_rsp_if.source  rsp
);

	logic    v_s1;
	opcode_t opcode_s1;
	word_t   word_s1;
	word_t   place_s1;
	word_t   sym_s1;

	logic    v_s2;
	word_t   word_s2;
	status_t status_s2;

	logic    adv_s2;
	logic    adv_s1;

	word_t   res;
	status_t st;

	word_t        diff;
	word_t        br_sum;
	logic [15:0]  hi;
	logic [15:0]  lo;
	logic         ts;
	word_t        toff;
	word_t        tsum;
	logic         thm_ok;
	logic         ns;
	logic         nj1;
	logic         nj2;
	logic [15:0]  nhi;
	logic [15:0]  nlo;

	assign adv_s2    = !v_s2 || rsp.ready;
	assign adv_s1    = !v_s1 || adv_s2;
	assign req.ready = adv_s1;

	assign rsp.valid    = v_s2;
	assign rsp.word_out = word_s2;
	assign rsp.status   = status_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= req.valid;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && req.valid) begin
			opcode_s1 <= req.opcode;
			word_s1   <= req.word_in;
			place_s1  <= req.place_addr;
			sym_s1    <= req.symbol_value;
		end
		if (adv_s2 && v_s1) begin
			word_s2   <= res;
			status_s2 <= st;
		end
	end

	// shared PC-relative term
	assign diff = sym_s1 - place_s1;

	// ARM branch: addend is the sign-extended 24-bit word offset
	assign br_sum = diff + {{6{word_s1[23]}}, word_s1[23:0], 2'b00};

	// Thumb BL/B.W pair decode, add, range check, re-encode
	assign hi   = word_s1[15:0];
	assign lo   = word_s1[31:16];
	assign ts   = hi[10];
	assign toff = {{7{ts}}, ts, ~(lo[13] ^ ts), ~(lo[11] ^ ts), hi[9:0], lo[10:0], 1'b0};
	assign tsum = toff + diff;
	assign thm_ok = tsum[0] && ((tsum[31:24] == 8'h00) || (tsum[31:24] == 8'hff));
	assign ns   = tsum[24];
	assign nj1  = ns ^ ~tsum[23];
	assign nj2  = ns ^ ~tsum[22];
	assign nhi  = (hi & THM_HI_KEEP) | {5'd0, ns, tsum[21:12]};
	assign nlo  = (lo & THM_LO_KEEP) | {2'd0, nj1, 1'b0, nj2, tsum[11:1]};

	always_comb begin
		res = word_s1;
		st  = ST_OK;
		case (opcode_s1)
			T_NONE: begin
				res = word_s1;
			end
			T_ABS32, T_RELATIVE: begin
				res = word_s1 + sym_s1;
			end
			T_REL32: begin
				res = word_s1 + diff;
			end
			T_PC24, T_PLT32, T_CALL, T_JUMP24: begin
				res = {word_s1[31:24], br_sum[25:2]};
			end
			T_V4BX: begin
				res = (word_s1 & V4BX_KEEP) | V4BX_MOV;
			end
			T_GLOB_DAT, T_JUMP_SLOT: begin
				res = sym_s1;
			end
			T_THM_CALL, T_THM_JUMP24: begin
				if (thm_ok) begin
					res = {nlo, nhi};
				end else begin
					st = ST_THUMB;
				end
			end
			default: begin
				st = ST_UNSUP;
			end
		endcase
	end

endmodule

`default_nettype wire
